[src/rof_pkg.sv]
// ----------------------------------------------------------------------------
// rof_pkg
// Shared types and constants for the 3x3 rank-order filter.
// ----------------------------------------------------------------------------
package rof_pkg;

    localparam int MAX_WIDTH_DEF  = 2048;
    localparam int MAX_HEIGHT_DEF = 2048;

    localparam int PIX_W   = 32;
    localparam int LANE_W  = 8;
    localparam int NLANE   = 4;
    localparam int NWIN    = 9;
    localparam int CFG_W   = 12;
    localparam int RANK_W  = 4;
    localparam int CNT_W   = 4;
    localparam int QDEPTH  = 4;

    localparam logic [CFG_W-1:0]  WIDTH_RST  = 12'd640;
    localparam logic [CFG_W-1:0]  HEIGHT_RST = 12'd480;
    localparam logic [RANK_W-1:0] RANK_RST   = 4'd5;
    localparam logic [RANK_W-1:0] RANK_MIN   = 4'd1;
    localparam logic [RANK_W-1:0] RANK_MAX   = 4'd9;
    localparam int                CENTER     = 4;

    typedef enum logic [1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_RANK   = 2'd2,
        CFG_MODE   = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [CFG_W-1:0]  width;
        logic [CFG_W-1:0]  height;
        logic [RANK_W-1:0] rank;
        logic              mode;
    } t_cfg;

    typedef struct packed {
        logic [NWIN-1:0][PIX_W-1:0] pix;
        logic                       mode;
        logic [RANK_W-1:0]          rank;
        logic                       fend;
    } t_win;

endpackage

[src/rof_ram.sv]
// ----------------------------------------------------------------------------
// rof_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module rof_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/rof_front.sv]
// ----------------------------------------------------------------------------
// rof_front
// Accept pixels, track position, run the line stores and the 3x3 window,
// and push complete interior windows into the queue.
// ----------------------------------------------------------------------------
module rof_front import rof_pkg::*; #(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  logic [PIX_W-1:0] i_s_tdata,
    input  logic             i_s_tuser,
    input  logic             i_q_full,
    output logic             o_push,
    output t_win             o_item
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    logic [CW-1:0]    r_col, r_pcol, acc_col;
    logic [RW-1:0]    r_row, r_prow, acc_row;
    logic [CW:0]      w_eff, col1;
    logic [RW:0]      h_eff, row1;
    logic [CW-1:0]    n_col;
    logic [RW-1:0]    n_row;
    logic             r_hv, r_fwd;
    logic [PIX_W-1:0] r_pix, r_fwd_up, r_fwd_lo;
    logic [PIX_W-1:0] up_rd, lo_rd, up_v, lo_v;
    logic [NWIN-1:0][PIX_W-1:0] r_win, n_win;
    logic [RANK_W-1:0] rank_eff;
    logic             accept, advance;

    always_comb begin
        if (i_cfg.width < CFG_W'(3)) begin
            w_eff = (CW+1)'(3);
        end else if (int'(i_cfg.width) > MAX_WIDTH) begin
            w_eff = (CW+1)'(MAX_WIDTH);
        end else begin
            w_eff = (CW+1)'(i_cfg.width);
        end
        if (i_cfg.height < CFG_W'(3)) begin
            h_eff = (RW+1)'(3);
        end else if (int'(i_cfg.height) > MAX_HEIGHT) begin
            h_eff = (RW+1)'(MAX_HEIGHT);
        end else begin
            h_eff = (RW+1)'(i_cfg.height);
        end
        if (i_cfg.rank < RANK_MIN) begin
            rank_eff = RANK_MIN;
        end else if (i_cfg.rank > RANK_MAX) begin
            rank_eff = RANK_MAX;
        end else begin
            rank_eff = i_cfg.rank;
        end
    end

    assign advance    = r_hv && !i_q_full;
    assign o_s_tready = !r_hv || !i_q_full;
    assign accept     = i_s_tvalid && o_s_tready;

    assign acc_col = i_s_tuser ? '0 : r_col;
    assign acc_row = i_s_tuser ? '0 : r_row;

    always_comb begin
        col1  = {1'b0, acc_col} + 1'b1;
        row1  = {1'b0, acc_row} + 1'b1;
        n_col = CW'(col1);
        n_row = acc_row;
        if (col1 >= w_eff) begin
            n_col = '0;
            n_row = (row1 >= h_eff) ? '0 : RW'(row1);
        end
    end

    rof_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
        .i_clk   (i_clk),
        .i_we    (advance),
        .i_waddr (r_pcol),
        .i_wdata (lo_v),
        .i_re    (accept),
        .i_raddr (acc_col),
        .o_rdata (up_rd)
    );

    rof_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_lower (
        .i_clk   (i_clk),
        .i_we    (advance),
        .i_waddr (r_pcol),
        .i_wdata (r_pix),
        .i_re    (accept),
        .i_raddr (acc_col),
        .o_rdata (lo_rd)
    );

    assign up_v = r_fwd ? r_fwd_up : up_rd;
    assign lo_v = r_fwd ? r_fwd_lo : lo_rd;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_win[i*3]   = r_win[i*3+1];
            n_win[i*3+1] = r_win[i*3+2];
        end
        n_win[2] = up_v;
        n_win[5] = lo_v;
        n_win[8] = r_pix;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_hv  <= 1'b0;
        end else begin
            if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
                r_hv  <= 1'b1;
            end else if (advance) begin
                r_hv  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pix    <= i_s_tdata;
            r_pcol   <= acc_col;
            r_prow   <= acc_row;
            r_fwd    <= advance && (r_pcol == acc_col);
            r_fwd_up <= lo_v;
            r_fwd_lo <= r_pix;
        end
        if (advance) begin
            r_win <= n_win;
        end
    end

    assign o_push      = advance && (r_prow >= RW'(2)) && (r_pcol >= CW'(2));
    assign o_item.pix  = n_win;
    assign o_item.mode = i_cfg.mode;
    assign o_item.rank = rank_eff;
    assign o_item.fend = ({1'b0, r_prow} == h_eff - 1'b1) && ({1'b0, r_pcol} == w_eff - 1'b1);

endmodule

[src/rof_queue.sv]
// ----------------------------------------------------------------------------
// rof_queue
// Short window queue between the front and the ranking pipeline.
// ----------------------------------------------------------------------------
module rof_queue import rof_pkg::*; #(
    parameter int DEPTH = QDEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_win i_item,
    input  logic i_pop,
    output t_win o_item,
    output logic o_full,
    output logic o_empty
);

    localparam int PW = $clog2(DEPTH);

    t_win           r_mem [DEPTH];
    logic [PW-1:0]  r_wp, r_rp;
    logic [PW:0]    r_cnt;

    assign o_full  = (r_cnt == (PW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (PW+1)'(DEPTH)) else $error("queue count overrun");
    a_no_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full)) else $error("push into full queue");
    a_no_udf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty)) else $error("pop from empty queue");
    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_cnt == $past(r_cnt) + 1'b1))
        else $error("queue count did not advance");

endmodule

[src/rof_back.sv]
// ----------------------------------------------------------------------------
// rof_back
// Ranking pipeline: count comparisons per lane, select the ranked value,
// and hold the result in the output register.
// ----------------------------------------------------------------------------
module rof_back import rof_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_win             i_item,
    input  logic             i_empty,
    output logic             o_pop,
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [PIX_W-1:0] o_m_tdata,
    output logic             o_m_tlast
);

    logic en;
    logic r_v1, r_v2, r_ov;
    t_win r_it1;
    logic [NLANE-1:0][NWIN-1:0][LANE_W-1:0] r_val;
    logic [NLANE-1:0][NWIN-1:0][CNT_W-1:0]  r_lt, r_le, n_lt, n_le;
    logic              r_mode2, r_fend2;
    logic [RANK_W-1:0] r_rank2;
    logic [NLANE-1:0][LANE_W-1:0] sel;
    logic [PIX_W-1:0] r_data;
    logic             r_last;

    assign en    = !r_ov || i_m_tready;
    assign o_pop = en && !i_empty;

    always_comb begin
        for (int l = 0; l < NLANE; l++) begin
            for (int i = 0; i < NWIN; i++) begin
                n_lt[l][i] = '0;
                n_le[l][i] = '0;
                for (int j = 0; j < NWIN; j++) begin
                    n_lt[l][i] = n_lt[l][i] + CNT_W'(r_it1.pix[j][l*LANE_W +: LANE_W]
                                                    < r_it1.pix[i][l*LANE_W +: LANE_W]);
                    n_le[l][i] = n_le[l][i] + CNT_W'(r_it1.pix[j][l*LANE_W +: LANE_W]
                                                    <= r_it1.pix[i][l*LANE_W +: LANE_W]);
                end
            end
        end
    end

    always_comb begin
        for (int l = 0; l < NLANE; l++) begin
            sel[l] = '0;
            for (int i = NWIN-1; i >= 0; i--) begin
                if ((r_lt[l][i] < r_rank2) && (r_rank2 <= r_le[l][i])) begin
                    sel[l] = r_val[l][i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_ov <= 1'b0;
        end else if (en) begin
            r_v1 <= !i_empty;
            r_v2 <= r_v1;
            r_ov <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_it1   <= i_item;
            r_lt    <= n_lt;
            r_le    <= n_le;
            r_mode2 <= r_it1.mode;
            r_rank2 <= r_it1.rank;
            r_fend2 <= r_it1.fend;
            for (int l = 0; l < NLANE; l++) begin
                for (int i = 0; i < NWIN; i++) begin
                    r_val[l][i] <= r_it1.pix[i][l*LANE_W +: LANE_W];
                end
            end
            r_data  <= r_mode2 ? {r_val[NLANE-1][CENTER], sel[2], sel[1], sel[0]}
                               : {sel[NLANE-1], {(PIX_W-LANE_W){1'b0}}};
            r_last  <= r_fend2;
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = r_data;
    assign o_m_tlast  = r_last;

endmodule

[src/rank_order_filter_3x3.sv]
// ----------------------------------------------------------------------------
// rank_order_filter_3x3
// 3x3 rank-order filter over an RGBA raster stream, interior pixels only.
// ----------------------------------------------------------------------------
// channel   dir  signals                       contents
// s_axis    in   i_s_tvalid/o_s_tready         pixel, frame_start
// m_axis    out  o_m_tvalid/i_m_tready         ranked pixel, frame_end
// cfg       in   i_cfg_we/i_cfg_addr/data      width, height, rank, mode
//
// One pixel per cycle while the queue is not full; the line-store read and
// window stage in the front are followed by three ranking stages.
// The four-entry queue lets input flow while the output stalls.
// Synchronous active-low reset; the line stores are not cleared.
// ----------------------------------------------------------------------------
module rank_order_filter_3x3 import rof_pkg::*; #(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_addr,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  logic [PIX_W-1:0] i_s_tdata,   // in_red, in_green, in_blue, in_alpha
    input  logic             i_s_tuser,   // frame_start
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [PIX_W-1:0] o_m_tdata,   // out_red, out_green, out_blue, out_alpha
    output logic             o_m_tlast
);

    t_cfg r_cfg;
    t_win push_item, pop_item;
    logic push, pop, q_full, q_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width  <= WIDTH_RST;
            r_cfg.height <= HEIGHT_RST;
            r_cfg.rank   <= RANK_RST;
            r_cfg.mode   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_WIDTH:  r_cfg.width  <= i_cfg_data;
                CFG_HEIGHT: r_cfg.height <= i_cfg_data;
                CFG_RANK:   r_cfg.rank   <= i_cfg_data[RANK_W-1:0];
                CFG_MODE:   r_cfg.mode   <= i_cfg_data[0];
            endcase
        end
    end

    rof_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_item     (push_item)
    );

    rof_queue #(.DEPTH(QDEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_item  (pop_item),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    rof_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (pop_item),
        .i_empty    (q_empty),
        .o_pop      (pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

[verif/tb_rank_order_filter_3x3.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rank_order_filter_3x3
// Streams small RGBA frames through the 3x3 rank-order filter under several
// width, height, rank and mode settings, predicts each interior result and
// checks it against the output stream with random gaps and back-pressure.
// ----------------------------------------------------------------------------
module tb_rank_order_filter_3x3;
    import rof_pkg::*;

    class rank_scoreboard;
        logic [31:0] upper_row [2048];
        logic [31:0] lower_row [2048];
        logic [31:0] win [3][3];
        int unsigned col_cnt, row_cnt;
        int unsigned cfg_w, cfg_h, cfg_r, cfg_m;
        logic [32:0] pending [$];
        int errors, checked, frames;

        function new();
            cfg_w = 640; cfg_h = 480; cfg_r = 5; cfg_m = 0;
            col_cnt = 0; row_cnt = 0; errors = 0; checked = 0; frames = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, int unsigned val);
            case (idx)
                CFG_WIDTH:  cfg_w = val & 12'hfff;
                CFG_HEIGHT: cfg_h = val & 12'hfff;
                CFG_RANK:   cfg_r = val & 4'hf;
                CFG_MODE:   cfg_m = val & 1;
            endcase
        endfunction

        function logic [7:0] rank_byte(int lane, int unsigned r);
            logic [7:0] v [9];
            int lt, le, k;
            k = 0;
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++) begin
                    v[k] = win[i][j][8*lane +: 8];
                    k++;
                end
            for (int i = 0; i < 9; i++) begin
                lt = 0; le = 0;
                for (int j = 0; j < 9; j++) begin
                    if (v[j] < v[i]) lt++;
                    if (v[j] <= v[i]) le++;
                end
                if (lt < r && r <= le) return v[i];
            end
            return 0;
        endfunction

        function void note_pixel(logic [31:0] pix, logic fs);
            int unsigned w, h, r, c, rw;
            logic [31:0] up, lo, res;
            w = cfg_w < 3 ? 3 : (cfg_w > 2048 ? 2048 : cfg_w);
            h = cfg_h < 3 ? 3 : (cfg_h > 2048 ? 2048 : cfg_h);
            r = cfg_r < 1 ? 1 : (cfg_r > 9 ? 9 : cfg_r);
            if (fs) begin
                col_cnt = 0; row_cnt = 0;
            end
            c = col_cnt; rw = row_cnt;
            up = upper_row[c]; lo = lower_row[c];
            upper_row[c] = lo; lower_row[c] = pix;
            for (int i = 0; i < 3; i++) begin
                win[i][0] = win[i][1]; win[i][1] = win[i][2];
            end
            win[0][2] = up; win[1][2] = lo; win[2][2] = pix;
            if (rw >= 2 && c >= 2) begin
                if (cfg_m) begin
                    res = {win[1][1][31:24], rank_byte(2, r), rank_byte(1, r),
                           rank_byte(0, r)};
                end else begin
                    res = {rank_byte(3, r), 24'h0};
                end
                pending.push_back({(rw == h - 1 && c == w - 1), res});
            end
            c++;
            if (c >= w) begin
                c = 0; rw++;
                if (rw >= h) rw = 0;
            end
            col_cnt = c; row_cnt = rw;
        endfunction

        function void check_result(logic [31:0] d, logic last);
            logic [32:0] exp;
            checked++;
            if (last) frames++;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %h last %b", d, last);
                return;
            end
            exp = pending.pop_front();
            if (exp[31:0] !== d || exp[32] !== last) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch #%0d: exp %h last %b, got %h last %b",
                             checked, exp[31:0], exp[32], d, last);
            end
        endfunction
    endclass

    logic i_clk = 0, i_rst_n = 0;
    logic i_cfg_we = 0;
    logic [1:0] i_cfg_addr = 0;
    logic [CFG_W-1:0] i_cfg_data = 0;
    logic i_s_tvalid = 0, i_s_tuser = 0, i_m_tready = 0;
    logic [PIX_W-1:0] i_s_tdata = 0;
    logic o_s_tready, o_m_tvalid, o_m_tlast;
    logic [PIX_W-1:0] o_m_tdata;

    rank_scoreboard sb;
    int sent = 0;
    bit hold_rx = 0;
    bit dense = 0;

    rank_order_filter_3x3 uut (.*);

    always #5 i_clk = ~i_clk;

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (dense || p < 55) return 0;
        if (p < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic write_reg(t_cfg_idx idx, int unsigned val);
        @(negedge i_clk);
        i_cfg_we = 1; i_cfg_addr = idx; i_cfg_data = val;
        sb.set_reg(idx, val);
        @(negedge i_clk);
        i_cfg_we = 0;
    endtask

    task automatic send_pixel(logic [31:0] pix, logic fs);
        int g;
        g = gap_len();
        repeat (g) @(negedge i_clk);
        i_s_tvalid = 1; i_s_tdata = pix; i_s_tuser = fs;
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_pixel(pix, fs);
        sent++;
        @(negedge i_clk);
        i_s_tvalid = 0;
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // frames written whole, so every window read was written first
    task automatic send_frame(int w, int h, int mode);
        logic [31:0] p;
        for (int y = 0; y < h; y++)
            for (int x = 0; x < w; x++) begin
                case (mode)
                    0: p = $urandom();
                    1: p = ($urandom_range(0, 1)) ? 32'hffffffff : 32'h0;
                    default: p = {4{8'($urandom_range(0, 3) * 85)}};
                endcase
                send_pixel(p, (x == 0 && y == 0));
            end
    endtask

    always @(posedge i_clk) begin
        if (o_m_tvalid && i_m_tready) sb.check_result(o_m_tdata, o_m_tlast);
    end

    initial begin : rx_side
        int g;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_rx) begin
                i_m_tready = 0;
            end else begin
                g = gap_len();
                if (g > 0) begin
                    i_m_tready = 0;
                    repeat (g - 1) @(negedge i_clk);
                    @(negedge i_clk);
                end
                i_m_tready = 1;
            end
        end
    end

    initial begin
        #50_000_000;
        $display("tb_rank_order_filter_3x3: done, errors");
        $finish;
    end

    initial begin : main
        int w, h;
        sb = new();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;
        // directed: smallest frame, extreme bytes, out-of-range ranks and both modes
        write_reg(CFG_WIDTH, 3);
        write_reg(CFG_HEIGHT, 3);
        for (int m = 0; m < 2; m++) begin
            write_reg(CFG_MODE, m);
            write_reg(CFG_RANK, 0);
            send_frame(3, 3, 1);
            drain();
            write_reg(CFG_RANK, 15);
            send_frame(3, 3, 2);
            drain();
        end
        write_reg(CFG_WIDTH, 1);
        write_reg(CFG_HEIGHT, 2);
        write_reg(CFG_RANK, 9);
        send_frame(3, 3, 0);
        drain();
        // back-pressure: hold the receiver while a frame streams in
        write_reg(CFG_WIDTH, 6);
        write_reg(CFG_HEIGHT, 5);
        write_reg(CFG_RANK, 5);
        fork
            begin
                hold_rx = 1;
                repeat (60) @(posedge i_clk);
                hold_rx = 0;
            end
            begin
                dense = 1;
                send_frame(6, 5, 0);
                dense = 0;
            end
        join
        drain();
        // random frames, mostly small, then one long-row frame
        while (sent < 790) begin
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(3, 8);
            h = $urandom_range(3, 6);
            write_reg(CFG_WIDTH, w);
            write_reg(CFG_HEIGHT, h);
            write_reg(CFG_RANK, $urandom_range(0, 15));
            write_reg(CFG_MODE, $urandom_range(0, 1));
            dense = ($urandom_range(0, 3) == 0);
            send_frame(w, h, $urandom_range(0, 5) == 0 ? 2 : 0);
            dense = 0;
            drain();
        end
        write_reg(CFG_WIDTH, 64);
        write_reg(CFG_HEIGHT, 3);
        write_reg(CFG_RANK, $urandom_range(1, 9));
        send_frame(64, 3, 0);
        drain();
        write_reg(CFG_WIDTH, 4095);
        write_reg(CFG_HEIGHT, 4095);
        drain();
        $display("sent %0d pixels, checked %0d results over %0d frames",
                 sent, sb.checked, sb.frames);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("tb_rank_order_filter_3x3: done, clean");
        end else begin
            $display("tb_rank_order_filter_3x3: done, errors");
        end
        $finish;
    end
endmodule

[files.f]
src/rof_pkg.sv
src/rof_ram.sv
src/rof_front.sv
src/rof_queue.sv
src/rof_back.sv
src/rank_order_filter_3x3.sv
verif/tb_rank_order_filter_3x3.sv
